>>> src/bst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the bounded set table.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Width of one stored element.
  localparam int unsigned VALUE_W = 32;
  // Width of the reported entry count field.
  localparam int unsigned COUNT_W = 5;
  // Width of the operation code.
  localparam int unsigned KIND_W  = 2;

  // Operation codes. The unused code behaves as a membership query.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // Broadcast controls from the top level to every cell.
  typedef struct packed {
    logic del_en;  // a delete is committed this cycle
    logic ins_en;  // an append of an absent value is committed this cycle
  } bst_cell_ctrl_t;

endpackage

>>> src/bst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_in_if
// Operation channel of the bounded set table: valid, ready and payload.
// ----------------------------------------------------------------------------
interface bst_in_if import bst_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> src/bst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_out_if
// Result channel of the bounded set table: valid, ready and payload.
// ----------------------------------------------------------------------------
interface bst_out_if import bst_pkg::*;;
  logic               valid;
  logic               ready;
  logic               was_member;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;
  logic               is_full;
  logic               rejected;

  modport source (output valid, output was_member, output entry_count, output is_empty,
                  output is_full, output rejected, input ready);
  modport sink   (input valid, input was_member, input entry_count, input is_empty,
                  input is_full, input rejected, output ready);
endinterface

>>> src/bounded_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_table
// Compacted set of up to CAPACITY distinct 32-bit values in insertion order.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY distinct 32-bit values in insertion order and
// answers one transaction on the result channel for every transaction taken on
// the operation channel: insert (append when absent), delete (remove and close
// the gap) or membership query. Each result gives whether the value was stored
// before, the count afterwards, the empty and full flags, and a reject flag for
// an insert of a new value into a full table. Values are compared as raw bit
// patterns. A transaction is registered when taken and commits once the result
// register is free; its result is registered at commit. The block takes the
// next operation in the cycle that commits the pending one, which gives one
// transaction per cycle in steady state while the result side keeps up; a
// stalled result holds the committing operation and the channel backs up
// behind it. The speed of a cycle is set by the row of compare cells and the
// match marker that runs from the lowest cell to the highest one. Stored values
// need no clearing after reset: only slots below the count are ever compared.
// ----------------------------------------------------------------------------
module bounded_set_table import bst_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bst_in_if.sink        in_i,
  bst_out_if.source     out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Pending operation, held from acceptance until it commits.
  logic               busy_q, busy_d;
  logic [KIND_W-1:0]  cmd_kind_q;
  logic [VALUE_W-1:0] cmd_value_q;

  // Number of occupied slots.
  logic [CW-1:0]      count_q, count_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic               was_member_q;
  logic [COUNT_W-1:0] entry_count_q;
  logic               is_empty_q;
  logic               is_full_q;
  logic               rejected_q;

  logic               commit;
  logic               in_take;
  logic               present;
  logic               full;
  logic               reject;
  bst_cell_ctrl_t     ctrl;

  logic [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY:0]  seen;

  // An operation commits when the result register is free or is being emptied.
  assign commit      = busy_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !busy_q || commit;
  assign in_take     = in_i.valid && in_i.ready;

  // The row of cells. The match marker enters the lowest cell as zero.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] upper;

    // The highest cell has no neighbor above; what it takes in is past the count.
    if (i == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entry_w[i+1];
    end

    bst_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .count_i (count_q),
      .value_i (cmd_value_q),
      .upper_i (upper),
      .seen_i  (seen[i]),
      .ctrl_i  (ctrl),
      .entry_o (entry_w[i]),
      .hit_o   (hit_vec[i]),
      .seen_o  (seen[i+1])
    );
  end

  // The marker leaving the highest cell tells whether any slot matched.
  assign present = seen[CAPACITY];
  assign full    = count_q == CW'(CAPACITY);

  // Decode the committing operation into cell controls and the new count.
  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    reject  = 1'b0;
    if (commit) begin
      unique case (kind_e'(cmd_kind_q))
        KIND_INSERT: begin
          if (!present) begin
            if (!full) begin
              ctrl.ins_en = 1'b1;
              count_d     = count_q + CW'(1);
            end else begin
              reject = 1'b1;
            end
          end
        end
        KIND_DELETE: begin
          if (present) begin
            ctrl.del_en = 1'b1;
            count_d     = count_q - CW'(1);
          end
        end
        default: begin
          // Membership query and the unused code leave the table untouched.
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (in_take) begin
      busy_d = 1'b1;
    end else if (commit) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_kind_q  <= in_i.kind;
      cmd_value_q <= in_i.value;
    end
    if (commit) begin
      was_member_q  <= present;
      entry_count_q <= COUNT_W'(count_d);
      is_empty_q    <= count_d == '0;
      is_full_q     <= count_d == CW'(CAPACITY);
      rejected_q    <= reject;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.was_member  = was_member_q;
  assign out_o.entry_count = entry_count_q;
  assign out_o.is_empty    = is_empty_q;
  assign out_o.is_full     = is_full_q;
  assign out_o.rejected    = rejected_q;

`ifndef SYNTHESIS
  // Stored values are distinct, so at most one slot can match.
  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(hit_vec))
    else $error("more than one slot matched the pending value");

  // The count never passes the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A committed append grows the count by exactly one.
  a_append_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not advance the count by one");

  // A committed delete shrinks the count by exactly one.
  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del_en |=> count_q == $past(count_q) - CW'(1))
    else $error("delete did not reduce the count by one");

  // A rejected insert is only reported against a full table.
  a_reject_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rejected_q) |-> (is_full_q && !was_member_q))
    else $error("reject reported without a full table");
`endif

endmodule

>>> src/bst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_cell
// One slot of the table: holds an element, compares it and shifts it down.
// ----------------------------------------------------------------------------
module bst_cell import bst_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic               clk_i,
  input  logic [CW-1:0]      count_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [VALUE_W-1:0] upper_i,
  input  logic               seen_i,
  input  bst_cell_ctrl_t     ctrl_i,
  output logic [VALUE_W-1:0] entry_o,
  output logic               hit_o,
  output logic               seen_o
);

  logic [VALUE_W-1:0] entry_q, entry_d;
  logic               occupied;

  assign occupied = CW'(IDX) < count_i;
  assign hit_o    = occupied && (entry_q == value_i);
  // The match marker travels upward: on a delete, every cell at or above the match moves down.
  assign seen_o   = seen_i | hit_o;
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.del_en && seen_o) begin
      entry_d = upper_i;
    end else if (ctrl_i.ins_en && (count_i == CW'(IDX))) begin
      entry_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
